// ===== hdl/tccs_pkg.sv =====
// Shared types and constants for the text console cursor/scroll core.
// No dependencies; used by text_console_cursor_scroll_core.
`timescale 1ns / 1ps

package tccs_pkg;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_DEL   = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_UP    = 3'd4,
    OP_DOWN  = 3'd5,
    OP_CLEAR = 3'd6,
    OP_READ  = 3'd7
  } opcode_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_EXEC   = 9'b000000010,
    ST_MAP    = 9'b000000100,
    ST_READ   = 9'b000001000,
    ST_RDATA  = 9'b000010000,
    ST_WRITE  = 9'b000100000,
    ST_SCROLL = 9'b001000000,
    ST_SWEEP  = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

endpackage

// ===== hdl/tccs_screen_ram.sv =====
// Screen cell store: one write port, one registered read port.
// No dependencies; instantiated by text_console_cursor_scroll_core.
`timescale 1ns / 1ps

module tccs_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tccs_addr_unit.sv =====
// Shared address adder: (a + b) modulo the cell count, both operands below it.
// No dependencies; instantiated by text_console_cursor_scroll_core.
`timescale 1ns / 1ps

module tccs_addr_unit #(
  parameter int CELLS = 2000,
  parameter int AW    = 11
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  output logic [AW-1:0] sum
);

  logic [AW:0] raw;
  logic [AW:0] wrapped;

  always_comb begin
    raw     = {1'b0, a} + {1'b0, b};
    wrapped = raw - (AW+1)'(CELLS);
    sum     = (raw >= (AW+1)'(CELLS)) ? wrapped[AW-1:0] : raw[AW-1:0];
  end

endmodule

// ===== hdl/text_console_cursor_scroll_core.sv =====
// Top level of the text console engine: sequencer, cursor, ring-of-rows screen.
// Depends on tccs_pkg, tccs_screen_ram and tccs_addr_unit.
`timescale 1ns / 1ps
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid / in_ready     | opcode, char_code, cell_address
//   out     | out_valid / out_ready   | cursor_row, cursor_col, cursor_position,
//           |                         | cell_data
//   cfg     | cfg_wr_en (no wait)     | cfg_wr_data (text_color)
//
// Cursor moves, newline and an out-of-range read go from the execute step straight to
// the finish step; put and delete pass through the address map step (the shared adder)
// and a write step, an in-range read through the map step and the registered RAM read.
// A scroll writes one blank per cycle into the row leaving the top, COLUMNS cells in all;
// clear blanks all ROWS*COLUMNS cells. Rows form a ring, so scrolling never copies cells.
// After reset a clearing pass over all ROWS*COLUMNS cells runs with in_ready low.
// The next item is accepted while a result waits; a stalled output holds the
// sequencer in its final step.

module text_console_cursor_scroll_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [10:0] cursor_position,
  output logic [15:0] cell_data,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  tccs_pkg::state_t  state;
  tccs_pkg::opcode_t op_q;
  logic [7:0]        ch_q;
  logic [10:0]       addr_q;
  logic [7:0]        text_color;
  logic [7:0]        blank_attr;
  logic              from_reset;

  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic [AW-1:0]     top_base;   // physical address of logical row 0
  logic [AW-1:0]     lpos;
  logic [AW-1:0]     phys;
  logic [15:0]       wr_data;
  logic [AW-1:0]     sweep_addr;
  logic [CW-1:0]     sweep_cnt;
  logic [15:0]       data_q;

  logic [AW-1:0]     unit_a;
  logic [AW-1:0]     unit_b;
  logic [AW-1:0]     unit_sum;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic [15:0]       ram_rdata;

  logic              last_row;
  logic              last_col;
  logic [RW-1:0]     ret_row;
  logic [CW-1:0]     ret_col;
  logic [RW-1:0]     nl_row;
  logic [RW-1:0]     adv_row;
  logic [CW-1:0]     adv_col;
  logic              adv_scroll;
  logic [AW-1:0]     cur_lpos;
  logic [AW-1:0]     ret_lpos;
  logic              addr_in_range;

  function automatic logic [AW-1:0] lin(input logic [RW-1:0] r, input logic [CW-1:0] c);
    lin = AW'(r * COLUMNS) + AW'(c);
  endfunction

  assign in_ready = (state == tccs_pkg::ST_IDLE);

  always_comb begin
    last_row = (row == RW'(ROWS - 1));
    last_col = (col == CW'(COLUMNS - 1));
    ret_row  = row;
    ret_col  = col;
    if (col == '0) begin
      if (row != '0) begin
        ret_row = row - 1'b1;
        ret_col = CW'(COLUMNS - 1);
      end
    end else begin
      ret_col = col - 1'b1;
    end
    // newline / wrap: stay on last row (screen scrolls) or step down
    nl_row     = last_row ? row : row + 1'b1;
    adv_row    = last_col ? nl_row : row;
    adv_col    = last_col ? '0 : col + 1'b1;
    adv_scroll = last_col && last_row;
    cur_lpos   = lin(row, col);
    ret_lpos   = lin(ret_row, ret_col);
    addr_in_range = (32'(addr_q) < CELLS);
  end

  // shared adder: map logical to physical, else step the sweep address
  always_comb begin
    if (state == tccs_pkg::ST_MAP) begin
      unit_a = lpos;
      unit_b = top_base;
    end else begin
      unit_a = sweep_addr;
      unit_b = AW'(1);
    end
  end

  tccs_addr_unit #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_addr_unit (
    .a   (unit_a),
    .b   (unit_b),
    .sum (unit_sum)
  );

  always_comb begin
    ram_we    = (state == tccs_pkg::ST_WRITE) || (state == tccs_pkg::ST_SCROLL) ||
                (state == tccs_pkg::ST_SWEEP);
    ram_waddr = (state == tccs_pkg::ST_WRITE) ? phys : sweep_addr;
    ram_wdata = (state == tccs_pkg::ST_WRITE) ? wr_data : {blank_attr, tccs_pkg::BLANK_CODE};
  end

  tccs_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (phys),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tccs_pkg::ST_SWEEP;
      sweep_addr <= '0;
      from_reset <= 1'b1;
      blank_attr <= tccs_pkg::RESET_COLOR;
      text_color <= tccs_pkg::RESET_COLOR;
      row        <= '0;
      col        <= '0;
      top_base   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        text_color <= cfg_wr_data;
      end
      // the finish step reloads the result register itself
      if (out_valid && out_ready && (state != tccs_pkg::ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        tccs_pkg::ST_IDLE: begin
          if (in_valid) begin
            op_q   <= tccs_pkg::opcode_t'(opcode);
            ch_q   <= char_code;
            addr_q <= cell_address;
            state  <= tccs_pkg::ST_EXEC;
          end
        end
        tccs_pkg::ST_EXEC: begin
          blank_attr <= text_color;
          data_q     <= '0;
          case (op_q)
            tccs_pkg::OP_PUT: begin
              if (ch_q == tccs_pkg::NEWLINE_CODE) begin
                row <= nl_row;
                col <= '0;
                if (last_row) begin
                  sweep_addr <= top_base;
                  sweep_cnt  <= '0;
                  state      <= tccs_pkg::ST_SCROLL;
                end else begin
                  state <= tccs_pkg::ST_FINISH;
                end
              end else begin
                lpos    <= cur_lpos;
                wr_data <= {text_color, ch_q};
                state   <= tccs_pkg::ST_MAP;
              end
            end
            tccs_pkg::OP_DEL: begin
              row     <= ret_row;
              col     <= ret_col;
              lpos    <= ret_lpos;
              wr_data <= {text_color, tccs_pkg::BLANK_CODE};
              state   <= tccs_pkg::ST_MAP;
            end
            tccs_pkg::OP_LEFT: begin
              row   <= ret_row;
              col   <= ret_col;
              state <= tccs_pkg::ST_FINISH;
            end
            tccs_pkg::OP_RIGHT: begin
              row <= adv_row;
              col <= adv_col;
              if (adv_scroll) begin
                sweep_addr <= top_base;
                sweep_cnt  <= '0;
                state      <= tccs_pkg::ST_SCROLL;
              end else begin
                state <= tccs_pkg::ST_FINISH;
              end
            end
            tccs_pkg::OP_UP: begin
              if (row != '0) begin
                row <= row - 1'b1;
              end
              state <= tccs_pkg::ST_FINISH;
            end
            tccs_pkg::OP_DOWN: begin
              if (!last_row) begin
                row <= row + 1'b1;
              end
              state <= tccs_pkg::ST_FINISH;
            end
            tccs_pkg::OP_CLEAR: begin
              row        <= '0;
              col        <= '0;
              top_base   <= '0;
              sweep_addr <= '0;
              from_reset <= 1'b0;
              state      <= tccs_pkg::ST_SWEEP;
            end
            tccs_pkg::OP_READ: begin
              if (addr_in_range) begin
                lpos  <= AW'(addr_q);
                state <= tccs_pkg::ST_MAP;
              end else begin
                state <= tccs_pkg::ST_FINISH;
              end
            end
            default: begin
              state <= tccs_pkg::ST_FINISH;
            end
          endcase
        end
        tccs_pkg::ST_MAP: begin
          phys  <= unit_sum;
          state <= (op_q == tccs_pkg::OP_READ) ? tccs_pkg::ST_READ : tccs_pkg::ST_WRITE;
        end
        tccs_pkg::ST_READ: begin
          state <= tccs_pkg::ST_RDATA;
        end
        tccs_pkg::ST_RDATA: begin
          data_q <= ram_rdata;
          state  <= tccs_pkg::ST_FINISH;
        end
        tccs_pkg::ST_WRITE: begin
          if (op_q == tccs_pkg::OP_PUT) begin
            row <= adv_row;
            col <= adv_col;
            if (adv_scroll) begin
              sweep_addr <= top_base;
              sweep_cnt  <= '0;
              state      <= tccs_pkg::ST_SCROLL;
            end else begin
              state <= tccs_pkg::ST_FINISH;
            end
          end else begin
            state <= tccs_pkg::ST_FINISH;
          end
        end
        tccs_pkg::ST_SCROLL: begin
          // blank the old top row; it becomes the new bottom row
          sweep_addr <= unit_sum;
          sweep_cnt  <= sweep_cnt + 1'b1;
          if (sweep_cnt == CW'(COLUMNS - 1)) begin
            top_base <= unit_sum;
            state    <= tccs_pkg::ST_FINISH;
          end
        end
        tccs_pkg::ST_SWEEP: begin
          sweep_addr <= unit_sum;
          if (sweep_addr == AW'(CELLS - 1)) begin
            state <= from_reset ? tccs_pkg::ST_IDLE : tccs_pkg::ST_FINISH;
          end
        end
        tccs_pkg::ST_FINISH: begin
          if (!out_valid || out_ready) begin
            cursor_row      <= 5'(row);
            cursor_col      <= 7'(col);
            cursor_position <= 11'(cur_lpos);
            cell_data       <= data_q;
            out_valid       <= 1'b1;
            state           <= tccs_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= tccs_pkg::ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (row <= RW'(ROWS - 1)) && (col <= CW'(COLUMNS - 1)))
    else $error("cursor outside the screen");

  a_top_base_range: assert property (@(posedge clk) disable iff (rst)
    top_base <= AW'(CELLS - 1))
    else $error("top row base outside the store");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == tccs_pkg::ST_EXEC))
    else $error("accepted item not executed");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    ((state == tccs_pkg::ST_FINISH) && (!out_valid || out_ready)) |=> (out_valid && in_ready))
    else $error("result not loaded on finish");

  a_scroll_base: assert property (@(posedge clk) disable iff (rst)
    ((state == tccs_pkg::ST_SCROLL) && (sweep_cnt == CW'(COLUMNS - 1))) |=>
      (top_base == sweep_addr))
    else $error("top row base not advanced past blanked row");
`endif

endmodule
